/* rtl/at_command_responder_unit_assert.svh */
// Assertion macros shared by the responder RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef AT_COMMAND_RESPONDER_UNIT_ASSERT_SVH
`define AT_COMMAND_RESPONDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define AT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define AT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define AT_ASSERT(lbl, prop)
`define AT_ASSERT_NEVER(lbl, cond)

`endif

`endif

/* rtl/atcr_pkg.sv */
`timescale 1ns / 1ps

package atcr_pkg;

  // Line buffer size: a line reaching LINE_BYTES-1 bytes is dropped.
  localparam int LINE_BYTES = 128;
  localparam int LenW       = $clog2(LINE_BYTES);

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharNull = 8'h00;

  // Text length saturates here; only lengths up to the long command matter.
  localparam int TextW     = 3;
  localparam int ShortLen  = 2;
  localparam int LongLen   = 6;

  // Queue of closed lines waiting for their reply.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Reply texts.
  localparam int RplIdxW = 5;
  localparam int OkLen   = 6;
  localparam int CsqLen  = 19;
  localparam int ErrLen  = 9;

  localparam logic [8*OkLen-1:0]  OkText  = "\r\nOK\r\n";
  localparam logic [8*CsqLen-1:0] CsqText = "\r\n+CSQ: 20,99\r\nOK\r\n";
  localparam logic [8*ErrLen-1:0] ErrText = "\r\nERROR\r\n";

  typedef enum logic [1:0] {
    KindOk  = 2'd0,
    KindCsq = 2'd1,
    KindErr = 2'd2
  } reply_kind_e;

  // One queued reply request.
  typedef struct packed {
    logic        valid;
    reply_kind_e kind;
  } cmd_t;

  function automatic logic [7:0] short_char(logic idx);
    logic [7:0] c;
    case (idx)
      1'b0:    c = "A";
      default: c = "T";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] long_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "A";
      3'd1:    c = "T";
      3'd2:    c = "+";
      3'd3:    c = "C";
      3'd4:    c = "S";
      3'd5:    c = "Q";
      default: c = CharNull;
    endcase
    return c;
  endfunction

  function automatic logic [RplIdxW-1:0] reply_len(reply_kind_e kind);
    logic [RplIdxW-1:0] n;
    case (kind)
      KindOk:  n = RplIdxW'(OkLen);
      KindCsq: n = RplIdxW'(CsqLen);
      default: n = RplIdxW'(ErrLen);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_byte(reply_kind_e kind, logic [RplIdxW-1:0] idx);
    logic [7:0] b;
    b = CharNull;
    case (kind)
      KindOk: begin
        if (idx < RplIdxW'(OkLen)) b = OkText[8*(OkLen-1-int'(idx)) +: 8];
      end
      KindCsq: begin
        if (idx < RplIdxW'(CsqLen)) b = CsqText[8*(CsqLen-1-int'(idx)) +: 8];
      end
      default: begin
        if (idx < RplIdxW'(ErrLen)) b = ErrText[8*(ErrLen-1-int'(idx)) +: 8];
      end
    endcase
    return b;
  endfunction

endpackage

/* rtl/atcr_front.sv */
`timescale 1ns / 1ps
`include "at_command_responder_unit_assert.svh"

module atcr_front
  import atcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       queue_full_i,
  output cmd_t       push_o
);

  logic [LenW-1:0]  len_q, len_d, len_inc;
  logic [TextW-1:0] text_q, text_d;
  logic             zero_q, zero_d;
  logic             short_ok_q, short_ok_d;
  logic             long_ok_q, long_ok_d;
  logic             accept, is_term;
  logic             short_hit, long_hit;

  assign s_axis_tready = !queue_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_term       = (s_axis_tdata == CharCr) || (s_axis_tdata == CharLf);
  assign len_inc       = len_q + LenW'(1);

  assign short_hit = (text_q < TextW'(ShortLen))
                  && (short_char(text_q[0]) == s_axis_tdata);
  assign long_hit  = (text_q < TextW'(LongLen))
                  && (long_char(text_q) == s_axis_tdata);

  always_comb begin
    len_d       = len_q;
    text_d      = text_q;
    zero_d      = zero_q;
    short_ok_d  = short_ok_q;
    long_ok_d   = long_ok_q;
    push_o.valid = 1'b0;
    if (short_ok_q && text_q == TextW'(ShortLen)) begin
      push_o.kind = KindOk;
    end else if (long_ok_q && text_q == TextW'(LongLen)) begin
      push_o.kind = KindCsq;
    end else begin
      push_o.kind = KindErr;
    end

    if (accept) begin
      if (is_term) begin
        // Close the line: answer only non-empty lines, then start afresh.
        if (len_q != '0) begin
          push_o.valid = 1'b1;
          len_d        = '0;
          text_d       = '0;
          zero_d       = 1'b0;
          short_ok_d   = 1'b1;
          long_ok_d    = 1'b1;
        end
      end else begin
        if (!zero_q) begin
          if (s_axis_tdata == CharNull) begin
            zero_d = 1'b1;
          end else begin
            short_ok_d = short_ok_q && short_hit;
            long_ok_d  = long_ok_q && long_hit;
            text_d     = (text_q == '1) ? text_q : text_q + TextW'(1);
          end
        end
        // Drop an overlong line silently.
        if (len_inc >= LenW'(LINE_BYTES - 1)) begin
          len_d      = '0;
          text_d     = '0;
          zero_d     = 1'b0;
          short_ok_d = 1'b1;
          long_ok_d  = 1'b1;
        end else begin
          len_d = len_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      text_q     <= '0;
      zero_q     <= 1'b0;
      short_ok_q <= 1'b1;
      long_ok_q  <= 1'b1;
    end else begin
      len_q      <= len_d;
      text_q     <= text_d;
      zero_q     <= zero_d;
      short_ok_q <= short_ok_d;
      long_ok_q  <= long_ok_d;
    end
  end

  `AT_ASSERT_NEVER(a_len_bound, len_q >= LenW'(LINE_BYTES - 1))
  `AT_ASSERT(a_text_within_line, LenW'(text_q) <= len_q)

endmodule

/* rtl/atcr_cmd_fifo.sv */
`timescale 1ns / 1ps
`include "at_command_responder_unit_assert.svh"

module atcr_cmd_fifo
  import atcr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t push_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o
);

  reply_kind_e       mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o       = (cnt_q == (FifoAw + 1)'(FifoDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.kind  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_q + FifoAw'(1);
      if (pop_i)        rd_q <= rd_q + FifoAw'(1);
      case ({push_i.valid, pop_i})
        2'b10:   cnt_q <= cnt_q + (FifoAw + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (FifoAw + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `AT_ASSERT_NEVER(a_no_overflow, push_i.valid && full_o)
  `AT_ASSERT_NEVER(a_no_underflow, pop_i && !head_o.valid)

endmodule

/* rtl/atcr_back.sv */
`timescale 1ns / 1ps

module atcr_back
  import atcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,   // reply_last
  output logic [1:0] m_axis_tuser    // [1:0] reply_kind
);

  logic               out_valid_q, out_valid_d;
  logic               active_q, active_d;
  reply_kind_e        kind_q, kind_d;
  logic [RplIdxW-1:0] idx_q, idx_d;
  logic [7:0]         data_q;
  logic               last_q;
  reply_kind_e        user_q;

  logic               load, have;
  reply_kind_e        cur_kind;
  logic [RplIdxW-1:0] cur_idx;
  logic               cur_last;

  assign load     = !out_valid_q || m_axis_tready;
  assign have     = active_q || head_i.valid;
  assign cur_kind = active_q ? kind_q : head_i.kind;
  assign cur_idx  = active_q ? idx_q : '0;
  assign cur_last = (cur_idx == reply_len(cur_kind) - RplIdxW'(1));
  assign pop_o    = load && !active_q && head_i.valid;

  always_comb begin
    out_valid_d = out_valid_q;
    active_d    = active_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = have;
      if (have) begin
        active_d = !cur_last;
        kind_d   = cur_kind;
        idx_d    = cur_idx + RplIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      kind_q      <= KindOk;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && have) begin
      data_q <= reply_byte(cur_kind, cur_idx);
      last_q <= cur_last;
      user_q <= cur_kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

endmodule

/* rtl/at_command_responder_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Signals                     Payload
// s_axis    in   tvalid/tready/tdata[7:0]    rx_byte
// m_axis    out  tvalid/tready/tdata[7:0]    tx_byte, tlast = reply_last,
//                tlast, tuser[1:0]           tuser = reply_kind
//
// Input bytes are taken at one per cycle while the reply queue has room; a line
// terminator hands a reply request to a four-entry queue in the same cycle.
// A reply of 6, 19 or 9 bytes leaves at one byte per cycle while m_axis_tready
// is high; its request goes through the queue, then the output register.
// s_axis_tready drops only while the reply queue is full.
// Reset (rst_ni, asynchronous, active low) empties the queue and output stage
// and clears the line tracking state.

module at_command_responder_unit
  import atcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,   // reply_last
  output logic [1:0] m_axis_tuser    // [1:0] reply_kind
);

  cmd_t push;
  cmd_t head;
  logic queue_full;
  logic pop;

  // Front: track the line with running prefix flags and classify it on close.
  atcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  // Hold pending reply requests so input and output stall independently.
  atcr_cmd_fifo u_cmd_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .full_o(queue_full)
  );

  // Back: advance through the canned reply text, one byte per output transfer.
  atcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

/* tb/at_command_responder_unit_check.sv */
`timescale 1ns / 1ps

module at_command_responder_unit_check
  import atcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  input  logic       m_axis_tlast,   // reply_last
  input  logic [1:0] m_axis_tuser,   // [1:0] reply_kind
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    reply_kind_e kind;
  } reply_beat_t;

  string short_cmd = "AT";
  string long_cmd  = "AT+CSQ";
  string ok_text   = "\r\nOK\r\n";
  string csq_text  = "\r\n+CSQ: 20,99\r\nOK\r\n";
  string err_text  = "\r\nERROR\r\n";

  logic [LenW-1:0] line_len;
  logic [LenW-1:0] text_len;
  logic            zero_seen;
  logic            short_ok;
  logic            long_ok;

  reply_beat_t reply_bytes_q[$];
  reply_beat_t head;
  int          fails = 0;

  task automatic clear_line();
    line_len  = '0;
    text_len  = '0;
    zero_seen = 1'b0;
    short_ok  = 1'b1;
    long_ok   = 1'b1;
  endtask

  task automatic queue_reply(input string txt, input reply_kind_e kind);
    reply_beat_t beat;
    for (int k = 0; k < txt.len(); k++) begin
      beat.data = txt[k];
      beat.last = (k == txt.len() - 1);
      beat.kind = kind;
      reply_bytes_q.push_back(beat);
    end
  endtask

  // Advance the line tracking by one received byte; queue the reply on a closing terminator.
  task automatic track_rx_byte(input logic [7:0] b);
    if (b == CharCr || b == CharLf) begin
      if (line_len != '0) begin
        if (short_ok && int'(text_len) == ShortLen) begin
          queue_reply(ok_text, KindOk);
        end else if (long_ok && int'(text_len) == LongLen) begin
          queue_reply(csq_text, KindCsq);
        end else begin
          queue_reply(err_text, KindErr);
        end
        clear_line();
      end
    end else begin
      // text stops at the first zero byte; later bytes only count towards the length
      if (!zero_seen) begin
        if (b == CharNull) begin
          zero_seen = 1'b1;
        end else begin
          if (int'(text_len) >= ShortLen || short_cmd[text_len] != b) short_ok = 1'b0;
          if (int'(text_len) >= LongLen || long_cmd[text_len] != b) long_ok = 1'b0;
          text_len = text_len + 1'b1;
        end
      end
      line_len = line_len + 1'b1;
      if (int'(line_len) >= LINE_BYTES - 1) clear_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      reply_bytes_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_bytes_q.size() == 0) begin
          $error("tx_byte 8'h%02h arrived with no reply pending", m_axis_tdata);
          fails++;
        end else begin
          head = reply_bytes_q.pop_front();
          if (m_axis_tdata !== head.data) begin
            $error("tx_byte: expected 8'h%02h, got 8'h%02h", head.data, m_axis_tdata);
            fails++;
          end
          if (m_axis_tlast !== head.last) begin
            $error("reply_last: expected %0b, got %0b", head.last, m_axis_tlast);
            fails++;
          end
          if (m_axis_tuser !== head.kind) begin
            $error("reply_kind: expected %0d, got %0d", head.kind, m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) track_rx_byte(s_axis_tdata);
    end
    pending_o    = reply_bytes_q.size();
    fail_count_o = fails;
  end

endmodule

/* tb/at_command_responder_unit_test.sv */
`timescale 1ns / 1ps

module at_command_responder_unit_test;
  import atcr_pkg::*;

  localparam int HoldCycles = 300;   // receiver hold-off for the back-pressure phase
  localparam int TailCycles = 40;    // quiet cycles after the last reply byte
  localparam int PhaseBytes = 36;    // random request bytes per idling phase

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] tx_byte
  logic       m_axis_tlast;            // reply_last
  logic [1:0] m_axis_tuser;            // [1:0] reply_kind

  int fail_count;
  int pending_replies;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_bytes     = 0;
  bit hold_go        = 1'b0;
  bit hold_done      = 1'b0;

  always #4 clk_i = ~clk_i;

  at_command_responder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Watch both channels, predict the replies and compare them.
  at_command_responder_unit_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_replies)
  );

  // Offer one request byte; idle first at the current rate, then hold it until accepted.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endtask

  // Any byte that does not close the line, zero included.
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CharCr || b == CharLf);
    return b;
  endfunction

  function automatic logic [7:0] rand_term();
    return $urandom_range(1) ? CharCr : CharLf;
  endfunction

  // Send random lines at the given idling rates until enough bytes have gone out.
  // Most lines are commands or near misses so the prefix tracking gets exercised;
  // the rest are junk, zero-byte lines and empty lines.
  task automatic run_random_phase(input int send_pct, input int stall_pct, input int n_bytes);
    int         stop_at;
    int         pick;
    int         pos;
    int         n;
    string      cmd;
    logic [7:0] bad;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    stop_at        = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(99);
      if ($urandom_range(1) != 0) begin
        cmd = "AT+CSQ";
      end else begin
        cmd = "AT";
      end
      if (pick < 40) begin
        push_text(cmd);
      end else if (pick < 55) begin
        // corrupt one byte of a command
        pos = $urandom_range(cmd.len() - 1);
        bad = 8'($urandom_range(255));
        for (int k = 0; k < cmd.len(); k++) push_byte((k == pos) ? bad : cmd[k]);
      end else if (pick < 63) begin
        // truncated command
        push_text(cmd.substr(0, $urandom_range(cmd.len() - 2)));
      end else if (pick < 71) begin
        // command with trailing characters
        push_text(cmd);
        n = $urandom_range(1, 3);
        repeat (n) push_byte(rand_body_byte());
      end else if (pick < 79) begin
        // zero byte ends the text; anything after it is ignored for matching
        push_text(cmd);
        push_byte(CharNull);
        n = $urandom_range(0, 4);
        repeat (n) push_byte(rand_body_byte());
      end else if (pick < 87) begin
        // junk, possibly with embedded terminators
        n = $urandom_range(1, 8);
        repeat (n) push_byte(8'($urandom_range(255)));
      end else if (pick < 93) begin
        n = $urandom_range(1, 3);
        repeat (n) push_byte(CharNull);
      end
      push_byte(rand_term());
      // CR LF pairs leave an empty line behind
      if ($urandom_range(99) < 30) push_byte(rand_term());
    end
  endtask

  // Receiver: stall at the current rate, or hold off for a long stretch when asked.
  initial begin : receiver
    int hold_left;
    hold_left = HoldCycles;
    forever begin
      @(negedge clk_i);
      if (hold_go && hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: both commands, empty lines, wrong case, zero bytes inside and
    // after the text, a line of zero bytes only, the all-ones byte.
    push_text("AT");
    push_byte(CharCr);
    push_text("AT+CSQ");
    push_byte(CharLf);
    push_byte(CharCr);
    push_byte(CharLf);
    push_text("at");
    push_byte(CharLf);
    push_text("A");
    push_byte(CharNull);
    push_text("T");
    push_byte(CharCr);
    push_text("AT");
    push_byte(CharNull);
    push_byte(8'hFF);
    push_byte(CharLf);
    push_byte(CharNull);
    push_byte(CharCr);

    // An overlong line is dropped silently; the command after it must be
    // answered on its own.
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    repeat (LINE_BYTES - 1) push_byte(rand_body_byte());
    push_text("AT");
    push_byte(CharLf);

    run_random_phase(0, 0, PhaseBytes);
    run_random_phase(54, 0, PhaseBytes);

    // Hold the receiver off while long replies keep being requested, so the
    // reply queue fills and the input stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    repeat (8) begin
      push_text("AT+CSQ");
      push_byte(CharCr);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (!hold_done) @(negedge clk_i);
    hold_go = 1'b0;

    run_random_phase(0, 54, PhaseBytes);
    run_random_phase(30, 30, PhaseBytes);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    // Drain the outstanding replies, then watch for stray bytes.
    while (pending_replies != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (fail_count == 0 && pending_replies == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/atcr_pkg.sv
rtl/atcr_front.sv
rtl/atcr_cmd_fifo.sv
rtl/atcr_back.sv
rtl/at_command_responder_unit.sv
tb/at_command_responder_unit_check.sv
tb/at_command_responder_unit_test.sv
